[sv/mh_pkg.sv]
// Shared constants, the cordic_t payload type and constant tables for the magnetometer heading unit.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mh_pkg;

  // Field widths
  localparam int RAW_W   = 16;
  localparam int FIELD_W = 25;
  localparam int HEAD_W  = 17;
  localparam int SEL_W   = 3;
  localparam int GAIN_W  = 9;
  localparam int DECL_W  = 15;

  // CORDIC arithmetic: x/y carry 16 fraction bits, angle is degrees * 2^16
  localparam int FRAC_W        = 16;
  localparam int XY_W          = 44;
  localparam int Z_W           = 25;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int STAGE_W       = $clog2(TABLE_LEN);

  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(90 * 65536);

  // Heading wrap, 1/256 degree units
  localparam int H_W = Z_W + 1;
  localparam int DEG_W = H_W - 8;
  localparam logic signed [DEG_W-1:0] FULL_TURN = DEG_W'(92160);
  localparam logic signed [H_W-1:0]   HALF_LSB  = H_W'(128);

  // APB register map
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_GAIN_SELECT = 1'b0;
  localparam logic REG_DECLINATION = 1'b1;

  localparam logic [SEL_W-1:0]  GAIN_SELECT_RST = SEL_W'(1);
  localparam logic [DECL_W-1:0] DECLINATION_RST = DECL_W'(670);

  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic                      zero;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] fz;
  } cordic_t;

  // Gain per count in 0.01 mG for each range code
  function automatic logic [GAIN_W-1:0] gain_of(input logic [SEL_W-1:0] sel);
    logic [GAIN_W-1:0] g;
    unique case (sel)
      3'd0: g = GAIN_W'(73);
      3'd1: g = GAIN_W'(92);
      3'd2: g = GAIN_W'(122);
      3'd3: g = GAIN_W'(152);
      3'd4: g = GAIN_W'(227);
      3'd5: g = GAIN_W'(256);
      3'd6: g = GAIN_W'(303);
      default: g = GAIN_W'(435);
    endcase
    return g;
  endfunction

  // round(atan(2^-i) in degrees * 2^16)
  function automatic logic signed [Z_W-1:0] atan_of(input logic [STAGE_W-1:0] idx);
    logic signed [Z_W-1:0] a;
    unique case (idx)
      5'd0:  a = Z_W'(2949120);
      5'd1:  a = Z_W'(1740967);
      5'd2:  a = Z_W'(919879);
      5'd3:  a = Z_W'(466945);
      5'd4:  a = Z_W'(234379);
      5'd5:  a = Z_W'(117304);
      5'd6:  a = Z_W'(58666);
      5'd7:  a = Z_W'(29335);
      5'd8:  a = Z_W'(14668);
      5'd9:  a = Z_W'(7334);
      5'd10: a = Z_W'(3667);
      5'd11: a = Z_W'(1833);
      5'd12: a = Z_W'(917);
      5'd13: a = Z_W'(458);
      5'd14: a = Z_W'(229);
      5'd15: a = Z_W'(115);
      5'd16: a = Z_W'(57);
      5'd17: a = Z_W'(29);
      5'd18: a = Z_W'(14);
      5'd19: a = Z_W'(7);
      5'd20: a = Z_W'(4);
      5'd21: a = Z_W'(2);
      5'd22: a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[sv/mh_if.sv]
// Valid/ready channel interfaces for raw samples and scaled results.
// Depends on mh_pkg for field widths.
`timescale 1ns / 1ps

interface mh_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mh_pkg::RAW_W-1:0]    raw_x;
  logic signed [mh_pkg::RAW_W-1:0]    raw_y;
  logic signed [mh_pkg::RAW_W-1:0]    raw_z;

  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface mh_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mh_pkg::FIELD_W-1:0]  field_x;
  logic signed [mh_pkg::FIELD_W-1:0]  field_y;
  logic signed [mh_pkg::FIELD_W-1:0]  field_z;
  logic [mh_pkg::HEAD_W-1:0]          heading_deg;

  modport source (output valid, field_x, field_y, field_z, heading_deg, input ready);
  modport sink   (input valid, field_x, field_y, field_z, heading_deg, output ready);
endinterface

[sv/mh_cfg.sv]
// APB register file: range code and declination.
// Depends on mh_pkg for the register map and reset values.
`timescale 1ns / 1ps

module mh_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mh_pkg::ADDR_W-1:0]         paddr,
  input  logic [mh_pkg::DATA_W-1:0]         pwdata,
  output logic [mh_pkg::DATA_W-1:0]         prdata,
  output logic                              pready,
  output logic [mh_pkg::SEL_W-1:0]          gain_sel,
  output logic signed [mh_pkg::DECL_W-1:0]  decl
);

  logic [mh_pkg::SEL_W-1:0]  gain_sel_r, gain_sel_nxt;
  logic [mh_pkg::DECL_W-1:0] decl_r, decl_nxt;
  logic                      wr_en;
  logic                      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    gain_sel_nxt = gain_sel_r;
    decl_nxt     = decl_r;
    if (wr_en) begin
      unique case (reg_idx)
        mh_pkg::REG_GAIN_SELECT: gain_sel_nxt = pwdata[mh_pkg::SEL_W-1:0];
        mh_pkg::REG_DECLINATION: decl_nxt     = pwdata[mh_pkg::DECL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mh_pkg::REG_GAIN_SELECT: prdata = {{(mh_pkg::DATA_W-mh_pkg::SEL_W){1'b0}}, gain_sel_r};
      mh_pkg::REG_DECLINATION:
        prdata = {{(mh_pkg::DATA_W-mh_pkg::DECL_W){decl_r[mh_pkg::DECL_W-1]}}, decl_r};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_sel_r <= mh_pkg::GAIN_SELECT_RST;
      decl_r     <= mh_pkg::DECLINATION_RST;
    end else begin
      gain_sel_r <= gain_sel_nxt;
      decl_r     <= decl_nxt;
    end
  end

  assign gain_sel = gain_sel_r;
  assign decl     = $signed(decl_r);

endmodule

[sv/mh_scale_cell.sv]
// Head cell of the chain: gain multiply per axis and quadrant pre-rotation.
// Depends on mh_pkg for widths, the gain table and the cordic_t payload.
`timescale 1ns / 1ps

module mh_scale_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mh_pkg::SEL_W-1:0]          gain_sel,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [mh_pkg::RAW_W-1:0]   raw_x,
  input  logic signed [mh_pkg::RAW_W-1:0]   raw_y,
  input  logic signed [mh_pkg::RAW_W-1:0]   raw_z,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output mh_pkg::cordic_t                   dn_data
);

  localparam int EXT_W = mh_pkg::FIELD_W - mh_pkg::RAW_W;
  localparam int PAD_W = mh_pkg::XY_W - mh_pkg::FIELD_W - mh_pkg::FRAC_W;

  logic                                valid_r, valid_nxt;
  mh_pkg::cordic_t                     data_r, data_nxt;
  logic                                adv;
  logic signed [mh_pkg::FIELD_W-1:0]   gain_ext;
  logic signed [mh_pkg::FIELD_W-1:0]   px, py, pz;
  logic signed [mh_pkg::XY_W-1:0]      xw, yw;

  assign adv      = !valid_r || dn_ready;
  assign up_ready = adv;
  assign gain_ext = {{(mh_pkg::FIELD_W-mh_pkg::GAIN_W){1'b0}}, mh_pkg::gain_of(gain_sel)};

  always_comb begin
    px = {{EXT_W{raw_x[mh_pkg::RAW_W-1]}}, raw_x} * gain_ext;
    py = {{EXT_W{raw_y[mh_pkg::RAW_W-1]}}, raw_y} * gain_ext;
    pz = {{EXT_W{raw_z[mh_pkg::RAW_W-1]}}, raw_z} * gain_ext;
    xw = {{PAD_W{px[mh_pkg::FIELD_W-1]}}, px, {mh_pkg::FRAC_W{1'b0}}};
    yw = {{PAD_W{py[mh_pkg::FIELD_W-1]}}, py, {mh_pkg::FRAC_W{1'b0}}};

    data_nxt.fx   = px;
    data_nxt.fy   = py;
    data_nxt.fz   = pz;
    data_nxt.zero = (px == '0) && (py == '0);
    data_nxt.x    = xw;
    data_nxt.y    = yw;
    data_nxt.z    = '0;
    // fold the left half plane into the right one
    if (px < 0) begin
      if (py >= 0) begin
        data_nxt.x = yw;
        data_nxt.y = -xw;
        data_nxt.z = mh_pkg::QUARTER_TURN;
      end else begin
        data_nxt.x = -yw;
        data_nxt.y = xw;
        data_nxt.z = -mh_pkg::QUARTER_TURN;
      end
    end
    valid_nxt = adv ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[sv/mh_cordic_cell.sv]
// One vectoring CORDIC micro-rotation with its own pipeline register.
// Depends on mh_pkg for the cordic_t payload and the arctangent table.
`timescale 1ns / 1ps

module mh_cordic_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mh_pkg::STAGE_W-1:0]    stage_idx,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  mh_pkg::cordic_t               up_data,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output mh_pkg::cordic_t               dn_data
);

  logic                            valid_r, valid_nxt;
  mh_pkg::cordic_t                 data_r, data_nxt;
  logic                            adv;
  logic signed [mh_pkg::XY_W-1:0]  xs, ys;
  logic signed [mh_pkg::Z_W-1:0]   ang;

  assign adv      = !valid_r || dn_ready;
  assign up_ready = adv;

  always_comb begin
    xs  = up_data.x >>> stage_idx;
    ys  = up_data.y >>> stage_idx;
    ang = mh_pkg::atan_of(stage_idx);
    data_nxt = up_data;
    // drive y toward zero
    if (up_data.y > 0) begin
      data_nxt.x = up_data.x + ys;
      data_nxt.y = up_data.y - xs;
      data_nxt.z = up_data.z + ang;
    end else begin
      data_nxt.x = up_data.x - ys;
      data_nxt.y = up_data.y + xs;
      data_nxt.z = up_data.z - ang;
    end
    valid_nxt = adv ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[sv/mh_wrap_cell.sv]
// Tail cell: declination, rounding to 1/256 degree, wrap into one turn, output register.
// Depends on mh_pkg for widths and the cordic_t payload.
`timescale 1ns / 1ps

module mh_wrap_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [mh_pkg::DECL_W-1:0]  decl,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  mh_pkg::cordic_t                   up_data,
  mh_out_if.source                          out_ch
);

  logic                                valid_r, valid_nxt;
  logic                                adv;
  logic signed [mh_pkg::FIELD_W-1:0]   fx_r, fy_r, fz_r;
  logic [mh_pkg::HEAD_W-1:0]           head_r, head_nxt;
  logic signed [mh_pkg::H_W-1:0]       ang, decl_sh, h_full, h_rnd;
  logic signed [mh_pkg::DEG_W-1:0]     h_deg, h_pos;

  assign adv      = !valid_r || out_ch.ready;
  assign up_ready = adv;

  always_comb begin
    // a zero vector has no direction; take its angle as zero
    ang     = up_data.zero ? '0
                           : {up_data.z[mh_pkg::Z_W-1], up_data.z};
    decl_sh = {{(mh_pkg::H_W-mh_pkg::DECL_W-8){decl[mh_pkg::DECL_W-1]}}, decl, 8'b0};
    h_full  = ang - decl_sh;
    h_rnd   = h_full + mh_pkg::HALF_LSB;
    h_deg   = h_rnd[mh_pkg::H_W-1:8];
    h_pos   = h_deg + mh_pkg::FULL_TURN;
    head_nxt = h_deg[mh_pkg::DEG_W-1] ? h_pos[mh_pkg::HEAD_W-1:0]
                                      : h_deg[mh_pkg::HEAD_W-1:0];
    valid_nxt = adv ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      fx_r   <= up_data.fx;
      fy_r   <= up_data.fy;
      fz_r   <= up_data.fz;
      head_r <= head_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.field_x     = fx_r;
  assign out_ch.field_y     = fy_r;
  assign out_ch.field_z     = fz_r;
  assign out_ch.heading_deg = head_r;

endmodule

[sv/magnetometer_heading_unit.sv]
// Magnetometer heading unit: gain scaling and CORDIC compass heading per sample.
// Top level; depends on mh_pkg, mh_if and the mh_cfg and mh_*_cell modules.
//
// Usage
//   in_ch  : valid/ready channel carrying one raw three-axis sample per beat.
//   out_ch : valid/ready channel carrying the scaled fields and the heading in
//            1/256 degree (0 to 92159) for each sample, in input order.
//   APB    : register 0 (byte address 0) is the range code, register 1
//            (byte address 4) the signed declination; pready is always high.
//            Write the registers only while no sample is in flight.
// Timing
//   A sample passes through one scaling cell, 16 CORDIC cells and one output
//   cell, each with its own register. The chain takes one sample per cycle
//   while out_ch does not stall; each cell holds its beat only while its
//   neighbor downstream is full and stalled.
// Reset and stall
//   Synchronous active-low reset empties the chain and loads range code 1 and
//   declination 670. When out_ch stalls, the chain fills up cell by cell, so
//   in_ch keeps accepting until every cell holds a sample.
`timescale 1ns / 1ps

module magnetometer_heading_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  mh_in_if.sink                       in_ch,
  mh_out_if.source                    out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mh_pkg::ADDR_W-1:0]   paddr,
  input  logic [mh_pkg::DATA_W-1:0]   pwdata,
  output logic [mh_pkg::DATA_W-1:0]   prdata,
  output logic                        pready
);

  logic [mh_pkg::SEL_W-1:0]          gain_sel;
  logic signed [mh_pkg::DECL_W-1:0]  decl;

  mh_pkg::cordic_t chain_data  [0:mh_pkg::NUM_CELLS];
  logic            chain_valid [0:mh_pkg::NUM_CELLS];
  logic            chain_ready [0:mh_pkg::NUM_CELLS];

  mh_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .gain_sel (gain_sel),
    .decl     (decl)
  );

  mh_scale_cell u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .gain_sel (gain_sel),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .raw_x    (in_ch.raw_x),
    .raw_y    (in_ch.raw_y),
    .raw_z    (in_ch.raw_z),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar g = 0; g < mh_pkg::NUM_CELLS; g++) begin : g_cell
    mh_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (mh_pkg::STAGE_W'(g)),
      .up_valid  (chain_valid[g]),
      .up_ready  (chain_ready[g]),
      .up_data   (chain_data[g]),
      .dn_valid  (chain_valid[g+1]),
      .dn_ready  (chain_ready[g+1]),
      .dn_data   (chain_data[g+1])
    );
  end

  mh_wrap_cell u_wrap (
    .clk      (clk),
    .rst_n    (rst_n),
    .decl     (decl),
    .up_valid (chain_valid[mh_pkg::NUM_CELLS]),
    .up_ready (chain_ready[mh_pkg::NUM_CELLS]),
    .up_data  (chain_data[mh_pkg::NUM_CELLS]),
    .out_ch   (out_ch)
  );

endmodule
